FILE: hdl/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg: shared types and constants of the peak min/max decimator
// Holds the lane geometry, the bucket count, the queue entry and the
// configuration bundle used by the front, queue and back modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pmd_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_W     = 16;
    localparam int MAG_W        = SAMPLE_W + 1;
    localparam int CHAN_W       = 4;
    localparam int FPB_W        = 32;

    localparam int BUCKETS      = 1024;
    localparam int BUCKET_W     = $clog2(BUCKETS) + 1;
    localparam int INDEX_W      = 10;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    localparam int S_TDATA_W    = MAX_CHANNELS * SAMPLE_W;
    localparam int M_PAYLOAD_W  = INDEX_W + 2 * SAMPLE_W;
    localparam int M_TDATA_W    = ((M_PAYLOAD_W + 7) / 8) * 8;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic signed [SAMPLE_W-1:0] FULL_POS = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT     = 2'd0,
        REG_FRAMES_PER_BUCKET = 2'd1
    } pmd_reg_idx_t;

    typedef struct packed {
        logic [CHAN_W-1:0] channel_count;
        logic [FPB_W-1:0]  frames_per_bucket;
    } pmd_cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] peak;
        logic                       eof;
    } pmd_entry_t;

endpackage

`default_nettype wire

FILE: hdl/pmd_front.sv
// ----------------------------------------------------------------------------
// pmd_front: frame intake and peak selection
// Accepts one frame per cycle while the queue has room and reduces
// its valid lanes to one sample of greatest magnitude, pushed to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_front
    import pmd_pkg::*;
(
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tlast,
    input  wire pmd_cfg_t              cfg,
    input  wire logic                  q_ready,
    output logic                       q_push,
    output pmd_entry_t                 q_entry
);

    logic signed [SAMPLE_W-1:0] lane_smp [MAX_CHANNELS];
    logic        [MAG_W-1:0]    lane_mag [MAX_CHANNELS];
    logic                       lane_vld [MAX_CHANNELS];

    logic signed [SAMPLE_W-1:0] l1_smp [4];
    logic        [MAG_W-1:0]    l1_mag [4];
    logic                       l1_vld [4];
    logic signed [SAMPLE_W-1:0] l2_smp [2];
    logic        [MAG_W-1:0]    l2_mag [2];
    logic                       l2_vld [2];

    // Valid lanes form a prefix: lane 0 always counts, lane c counts when
    // the configured count exceeds c. Counts above eight saturate naturally.
    always_comb begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            lane_smp[c] = $signed(s_tdata[c*SAMPLE_W +: SAMPLE_W]);
            lane_mag[c] = lane_smp[c][SAMPLE_W-1]
                        ? MAG_W'(~{lane_smp[c][SAMPLE_W-1], lane_smp[c]} + 1'b1)
                        : {1'b0, lane_smp[c]};
            lane_vld[c] = (c == 0) || (cfg.channel_count > CHAN_W'(c));
        end
    end

    // Pairwise tree; the right candidate wins only on a strictly greater
    // magnitude, so ties go to the lower-numbered channel.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (lane_vld[2*i+1] && (lane_mag[2*i+1] > lane_mag[2*i])) begin
                l1_smp[i] = lane_smp[2*i+1];
                l1_mag[i] = lane_mag[2*i+1];
            end else begin
                l1_smp[i] = lane_smp[2*i];
                l1_mag[i] = lane_mag[2*i];
            end
            l1_vld[i] = lane_vld[2*i];
        end
        for (int i = 0; i < 2; i++) begin
            if (l1_vld[2*i+1] && (l1_mag[2*i+1] > l1_mag[2*i])) begin
                l2_smp[i] = l1_smp[2*i+1];
                l2_mag[i] = l1_mag[2*i+1];
            end else begin
                l2_smp[i] = l1_smp[2*i];
                l2_mag[i] = l1_mag[2*i];
            end
            l2_vld[i] = l1_vld[2*i];
        end
        if (l2_vld[1] && (l2_mag[1] > l2_mag[0])) begin
            q_entry.peak = l2_smp[1];
        end else begin
            q_entry.peak = l2_smp[0];
        end
        q_entry.eof = s_tlast;
    end

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

endmodule

`default_nettype wire

FILE: hdl/pmd_queue.sv
// ----------------------------------------------------------------------------
// pmd_queue: short FIFO between peak selection and bucket accumulation
// Lets the intake keep taking frames while the result side is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_queue
    import pmd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire pmd_entry_t push_entry,
    output logic            push_ready,
    input  wire logic       pop,
    output logic            head_valid,
    output pmd_entry_t      head_entry
);

    pmd_entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg, count_next;
    logic                    do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    assign do_push = push && push_ready;
    assign do_pop  = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pmd_back.sv
// ----------------------------------------------------------------------------
// pmd_back: bucket accumulation and result register
// Folds each selected peak into the running minimum and maximum, closes
// buckets and holds the finished result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_back
    import pmd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pmd_cfg_t             cfg,
    input  wire logic                 head_valid,
    input  wire pmd_entry_t           head_entry,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    logic [FPB_W-1:0]           frame_cnt_reg, frame_cnt_next;
    logic [BUCKET_W-1:0]        bucket_reg, bucket_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic                       m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]       m_data_reg, m_data_next;
    logic                       m_last_reg, m_last_next;

    logic signed [SAMPLE_W-1:0] min_upd, max_upd;
    logic [FPB_W-1:0]           frame_inc, fpb_eff;
    logic                       all_done, emit, last;

    assign pop = head_valid && (!m_valid_reg || m_tready);

    always_comb begin
        all_done  = (bucket_reg >= BUCKET_W'(BUCKETS));
        min_upd   = (head_entry.peak < min_reg) ? head_entry.peak : min_reg;
        max_upd   = (head_entry.peak > max_reg) ? head_entry.peak : max_reg;
        frame_inc = (&frame_cnt_reg) ? frame_cnt_reg : frame_cnt_reg + 1'b1;
        fpb_eff   = (cfg.frames_per_bucket == '0) ? FPB_W'(1) : cfg.frames_per_bucket;
        emit      = !all_done && ((frame_inc >= fpb_eff) || head_entry.eof);
        last      = head_entry.eof || (bucket_reg == BUCKET_W'(BUCKETS - 1));

        frame_cnt_next = frame_cnt_reg;
        bucket_next    = bucket_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        m_valid_next   = m_tready ? 1'b0 : m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;

        if (pop) begin
            if (all_done) begin
                if (head_entry.eof) begin
                    frame_cnt_next = '0;
                    bucket_next    = '0;
                    min_next       = FULL_POS;
                    max_next       = FULL_NEG;
                end
            end else if (emit) begin
                m_valid_next = 1'b1;
                m_data_next  = M_TDATA_W'({max_upd, min_upd, bucket_reg[INDEX_W-1:0]});
                m_last_next  = last;
                frame_cnt_next = '0;
                min_next       = FULL_POS;
                max_next       = FULL_NEG;
                bucket_next    = head_entry.eof ? '0 : bucket_reg + 1'b1;
            end else begin
                frame_cnt_next = frame_inc;
                min_next       = min_upd;
                max_next       = max_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_cnt_reg <= '0;
            bucket_reg    <= '0;
            min_reg       <= FULL_POS;
            max_reg       <= FULL_NEG;
            m_valid_reg   <= 1'b0;
        end else begin
            frame_cnt_reg <= frame_cnt_next;
            bucket_reg    <= bucket_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

FILE: hdl/peak_minmax_decimator_core.sv
// ----------------------------------------------------------------------------
// peak_minmax_decimator_core: min/max peak decimation of multichannel audio
// Reduces a stream of Q1.15 frames to per-bucket minimum and maximum peaks
// for waveform previews.
// ----------------------------------------------------------------------------
// Usage:
// The slave side takes one frame per transaction: eight Q1.15 lane samples
// in s_tdata and the end-of-file flag in s_tlast. Of the first channel_count
// lanes, the sample of greatest magnitude (sign kept, lowest lane on a tie)
// feeds a running minimum and maximum. After frames_per_bucket frames, or on
// an end-of-file frame, the master side delivers one transaction with the
// bucket index, minimum and maximum; m_tlast marks the final bucket. After
// bucket 1023 frames are dropped until an end-of-file frame restarts counting.
// Throughput is one frame per clock while the queue has room. A result appears
// on m_tvalid after the transaction that closes its bucket: the frame is
// written into the four-entry queue at the accepting edge and then passes the
// accumulator into the output register. When the receiver holds m_tready low,
// the result stays in the output register and the queue absorbs up to four
// further frames before s_tready drops. A synchronous low aresetn empties the
// queue, drops any held result and restores channel_count = 1 and
// frames_per_bucket = 1.
// Configuration writes are always accepted (cfg_ready is high) and must only
// be issued while no frame is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_minmax_decimator_core
    import pmd_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Configuration write channel.
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    // Frame input.
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [S_TDATA_W-1:0]    s_tdata,   // sample_0 .. sample_7, 16 bits each
    input  wire logic                    s_tlast,   // end_of_file
    // Bucket results.
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [M_TDATA_W-1:0]         m_tdata,   // bucket_index, bucket_min, bucket_max, zero pad
    output logic                         m_tlast    // final_bucket
);

    pmd_cfg_t    cfg_reg, cfg_next;
    logic        cfg_write;

    logic        q_push, q_ready, q_pop, q_head_valid;
    pmd_entry_t  q_push_entry, q_head_entry;

    // Register file: unknown indexes are accepted and ignored.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (pmd_reg_idx_t'(cfg_index))
                REG_CHANNEL_COUNT:     cfg_next.channel_count     = cfg_data[CHAN_W-1:0];
                REG_FRAMES_PER_BUCKET: cfg_next.frames_per_bucket = cfg_data[FPB_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_count     <= CHAN_W'(1);
            cfg_reg.frames_per_bucket <= FPB_W'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: peak selection across the active lanes.
    pmd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cfg      (cfg_reg),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_entry  (q_push_entry)
    );

    // Decoupling queue so that output stalls do not stop intake at once.
    pmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    // Back: bucket accumulation and the output register.
    pmd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

FILE: hdl/pmd_checker.sv
// ----------------------------------------------------------------------------
// pmd_checker: port-level checks of the peak min/max decimator
// Watches the top-level ports and flags output protocol and content slips.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_checker
    import pmd_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic [M_TDATA_W-1:0]    m_tdata,
    input  wire logic                    m_tlast
);

    // A stalled result holds its payload until taken.
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed or vanished");

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The last bucket index always marks the final bucket.
    a_last_index_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[INDEX_W-1:0] == INDEX_W'(BUCKETS - 1)) |-> m_tlast)
        else $error("last bucket index without final flag");

    // A bucket's minimum never exceeds its maximum.
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[INDEX_W +: SAMPLE_W])
                      <= $signed(m_tdata[INDEX_W + SAMPLE_W +: SAMPLE_W])))
        else $error("bucket minimum above maximum");

endmodule

bind peak_minmax_decimator_core pmd_checker u_pmd_checker (.*);

`default_nettype wire
